[rtl/dpf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpf_pkg
// Shared types and constants of the duplicate packet filter.
// ----------------------------------------------------------------------------
package dpf_pkg;

    // Widths fixed by the word formats
    localparam int CAP_W  = 9;
    localparam int ID_W   = 32;
    localparam int KEY_W  = 2 * ID_W;
    localparam int FILL_W = 9;

    // Defaults and reset values
    localparam int              DEPTH_DEFAULT = 256;
    localparam logic [CAP_W-1:0] CAP_RESET    = 9'd256;
    localparam logic [FILL_W-1:0] FILL_MAX    = 9'h1FF;

    // Command codes
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // Input word
    typedef struct packed {
        logic            command;
        logic [ID_W-1:0] sender_id;
        logic [ID_W-1:0] packet_id;
    } item_t;

    // Result word
    typedef struct packed {
        logic              found;
        logic              added;
        logic [FILL_W-1:0] fill_count;
    } result_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic             launch;
        logic             wr_en;
        logic [KEY_W-1:0] key;
    } cell_bcast_t;

endpackage : dpf_pkg
`default_nettype wire

[rtl/duplicate_packet_filter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// duplicate_packet_filter_unit
// FIFO-replacement cache of (sender, packet) pairs built as a chain of cells.
//
//   channel   signals                        transfer
//   --------  -----------------------------  ---------------------------
//   item      start, busy, item              start & !busy
//   result    done, result                   done (one cycle, no stall)
//   config    cfg_valid, cfg_ready, cfg_data cfg_valid & cfg_ready
//
// Each word goes through a launch step, a search token walking the cell
// chain one cell per clock, a finish step, then the registered result strobe.
// The result appears the cycle after the token leaves the last cell; start
// may be taken again in that same cycle.
// Reset sets capacity to 256, fill count and write pointer to zero; the
// pair slots need no clearing pass. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module duplicate_packet_filter_unit
    import dpf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire item_t            item,
    output logic                  done,
    output result_t               result,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CAP_W-1:0] cfg_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cell_bcast_t   bcast;
    logic [PW-1:0] wr_ptr;
    logic [CW-1:0] count;
    logic          tok_chain [0:DEPTH];
    logic          hit_chain [0:DEPTH];

    dpf_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .result    (result),
        .done      (done),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .bcast     (bcast),
        .wr_ptr    (wr_ptr),
        .count     (count),
        .tok_last  (tok_chain[DEPTH]),
        .hit_last  (hit_chain[DEPTH])
    );

    // Inject the token with a clear hit flag at the head of the chain
    assign tok_chain[0] = bcast.launch;
    assign hit_chain[0] = 1'b0;

    // Row of slot cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        dpf_cell #(
            .DEPTH (DEPTH),
            .IDX   (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .bcast   (bcast),
            .wr_ptr  (wr_ptr),
            .count   (count),
            .tok_in  (tok_chain[i]),
            .hit_in  (hit_chain[i]),
            .tok_out (tok_chain[i+1]),
            .hit_out (hit_chain[i+1])
        );
    end

endmodule : duplicate_packet_filter_unit
`default_nettype wire

[rtl/dpf_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpf_cell
// One ring slot: holds a stored pair, compares it with the broadcast key when
// the search token passes, and hands token and hit flag to the next cell.
// ----------------------------------------------------------------------------
module dpf_cell
    import dpf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int IDX   = 0
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire cell_bcast_t                  bcast,
    input  wire logic [$clog2(DEPTH)-1:0]     wr_ptr,
    input  wire logic [$clog2(DEPTH+1)-1:0]   count,
    input  wire logic                         tok_in,
    input  wire logic                         hit_in,
    output logic                              tok_out,
    output logic                              hit_out
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [KEY_W-1:0] entry_reg;
    logic             tok_reg;
    logic             hit_reg;
    logic             hit_next;
    logic             live;

    // Slot holds a pair only below the fill count
    assign live     = (CW'(IDX) < count);
    assign hit_next = hit_in | (tok_in & live & (entry_reg == bcast.key));

    // Advance token and hit flag one cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
            hit_reg <= hit_next;
        end
    end

    // Store a new pair when this slot is addressed
    always_ff @(posedge clk)
    begin
        if (bcast.wr_en && (wr_ptr == PW'(IDX)))
        begin
            entry_reg <= bcast.key;
        end
    end

    assign tok_out = tok_reg;
    assign hit_out = hit_reg;

endmodule : dpf_cell
`default_nettype wire

[rtl/dpf_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpf_ctrl
// Command, capacity register, write pointer and fill count; launches the
// search token into the cell chain and finishes the word when it returns.
// ----------------------------------------------------------------------------
module dpf_ctrl
    import dpf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire item_t                        item,
    output logic                              busy,
    output result_t                           result,
    output logic                              done,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [CAP_W-1:0]             cfg_data,
    output cell_bcast_t                       bcast,
    output logic [$clog2(DEPTH)-1:0]          wr_ptr,
    output logic [$clog2(DEPTH+1)-1:0]        count,
    input  wire logic                         tok_last,
    input  wire logic                         hit_last
);

    localparam int PW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CAP_W-1:0]  capacity_reg;
    logic [PW-1:0]     ptr_reg, ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [KEY_W-1:0]  key_reg;
    logic              insert_reg;
    logic              launch_reg;
    result_t           result_reg, result_next;
    logic              done_reg;

    logic [CMPW-1:0]   cap_ext;
    logic [CMPW-1:0]   depth_c;
    logic [CMPW-1:0]   cap_eff;
    logic              cap_nz;
    logic [PW-1:0]     ptr_use;
    logic [CMPW-1:0]   ptr_inc;
    logic [CW-1:0]     count_inc;
    logic [CMPW-1:0]   count_after;
    logic              finish;
    logic              found_w;
    logic              add_w;
    logic              cfg_wr;

    // Effective capacity saturates at the number of cells
    assign cap_ext = CMPW'(capacity_reg);
    assign depth_c = CMPW'(DEPTH);
    assign cap_eff = (cap_ext > depth_c) ? depth_c : cap_ext;
    assign cap_nz  = (cap_eff != '0);

    // Result of the search once the token leaves the last cell
    assign finish  = (state_reg == ST_SCAN) && tok_last;
    assign found_w = cap_nz & hit_last;
    assign add_w   = cap_nz & (insert_reg == CMD_INSERT) & ~hit_last;

    // Pointer wrap and fill growth for an insert
    assign ptr_use   = (CMPW'(ptr_reg) >= cap_eff) ? '0 : ptr_reg;
    assign ptr_inc   = CMPW'(ptr_use) + CMPW'(1);
    assign count_inc = (CMPW'(count_reg) < cap_eff) ? (count_reg + CW'(1)) : count_reg;

    assign cfg_wr    = cfg_valid & cfg_ready;

    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        count_next  = count_reg;
        result_next = result_reg;
        count_after = CMPW'(count_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tok_last)
                begin
                    state_next = ST_IDLE;
                    if (add_w)
                    begin
                        ptr_next    = (ptr_inc >= cap_eff) ? '0 : ptr_inc[PW-1:0];
                        count_next  = count_inc;
                        count_after = CMPW'(count_inc);
                    end
                    result_next.found      = found_w;
                    result_next.added      = add_w;
                    result_next.fill_count = (count_after > CMPW'(FILL_MAX)) ?
                                             FILL_MAX : count_after[FILL_W-1:0];
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state, apply capacity writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            capacity_reg <= CAP_RESET;
            ptr_reg      <= '0;
            count_reg    <= '0;
            launch_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= (state_reg == ST_IDLE) && start;
            done_reg   <= finish;
            if (cfg_wr)
            begin
                capacity_reg <= cfg_data;
                ptr_reg      <= '0;
                count_reg    <= '0;
            end
            else
            begin
                ptr_reg   <= ptr_next;
                count_reg <= count_next;
            end
        end
    end

    // Latch the word and the result payload
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            key_reg    <= {item.sender_id, item.packet_id};
            insert_reg <= item.command;
        end
        result_reg <= result_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = (state_reg == ST_IDLE);
    assign done         = done_reg;
    assign result       = result_reg;
    assign bcast.launch = launch_reg;
    assign bcast.wr_en  = finish & add_w;
    assign bcast.key    = key_reg;
    assign wr_ptr       = ptr_use;
    assign count        = count_reg;

`ifndef SYNTHESIS
    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_SCAN))
        else $error("result strobe without a finished search");

    a_fill_in_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(count_reg) <= cap_eff)
        else $error("fill count above capacity");

    a_ptr_in_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        cap_nz |-> (CMPW'(ptr_reg) < cap_eff))
        else $error("write pointer outside the ring");

    a_added_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(result_reg.added && result_reg.found))
        else $error("pair reported both found and added");

    a_launch_once: assert property (@(posedge clk) disable iff (!rst_n)
        launch_reg |=> !launch_reg && (state_reg == ST_SCAN))
        else $error("search token launched twice");
`endif

endmodule : dpf_ctrl
`default_nettype wire

[test/tb_duplicate_packet_filter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_duplicate_packet_filter_unit
// Self-checking bench for the duplicate packet filter. A scoreboard keeps its
// own ring of (sender, packet) pairs and predicts found/added/fill for every
// accepted word. A directed pass covers the ID extremes, both commands, the
// disabled cache and eviction. Random phases then run under several capacity
// settings, including zero and values above the depth. The sender drives in
// bursts with random gaps.
// ----------------------------------------------------------------------------
module tb_duplicate_packet_filter_unit;
    import dpf_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int MEM_DEPTH      = DEPTH_DEFAULT;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int POOL_SIZE      = 64;

    // Scoreboard: mirror of the pair ring plus the queue of pending results
    class dup_filter_scoreboard;
        logic [KEY_W-1:0] pair_mem [MEM_DEPTH];
        int unsigned      wr_ptr;
        int unsigned      valid_cnt;
        int unsigned      cap_eff;
        result_t          expected_q [$];
        int               errors;

        function new();
            wr_ptr    = 0;
            valid_cnt = 0;
            cap_eff   = MEM_DEPTH;
            errors    = 0;
        endfunction

        // Apply a capacity write: saturate at the depth, clear ring state
        function void note_config(logic [CAP_W-1:0] cap);
            cap_eff   = (cap > MEM_DEPTH) ? MEM_DEPTH : cap;
            wr_ptr    = 0;
            valid_cnt = 0;
        endfunction

        // Search the filled slots, insert if asked and absent, queue the result
        function void note_item(item_t w);
            logic [KEY_W-1:0] key;
            logic             hit;
            result_t          exp;
            key = {w.sender_id, w.packet_id};
            hit = 1'b0;
            exp = '0;
            if (cap_eff != 0)
            begin
                for (int i = 0; i < valid_cnt; i++)
                begin
                    if (pair_mem[i] == key)
                        hit = 1'b1;
                end
                if (w.command == CMD_INSERT && !hit)
                begin
                    if (wr_ptr >= cap_eff)
                        wr_ptr = 0;
                    pair_mem[wr_ptr] = key;
                    wr_ptr++;
                    if (wr_ptr >= cap_eff)
                        wr_ptr = 0;
                    if (valid_cnt < cap_eff)
                        valid_cnt++;
                    exp.added = 1'b1;
                end
            end
            exp.found      = hit;
            exp.fill_count = FILL_W'((valid_cnt > FILL_MAX) ? FILL_MAX : valid_cnt);
            expected_q.push_back(exp);
        endfunction

        // Compare one result word against the oldest expectation
        function void check_result(result_t got);
            result_t exp;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual found=%0d added=%0d fill=%0d",
                         $time, got.found, got.added, got.fill_count);
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            if (got.found !== exp.found)
            begin
                $display("%0t: found mismatch, expected %0d actual %0d",
                         $time, exp.found, got.found);
                errors++;
            end
            if (got.added !== exp.added)
            begin
                $display("%0t: added mismatch, expected %0d actual %0d",
                         $time, exp.added, got.added);
                errors++;
            end
            if (got.fill_count !== exp.fill_count)
            begin
                $display("%0t: fill_count mismatch, expected %0d actual %0d",
                         $time, exp.fill_count, got.fill_count);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             busy;
    item_t            item      = '0;
    logic             done;
    result_t          result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data  = '0;

    dup_filter_scoreboard sb;
    logic [KEY_W-1:0]     recent_pairs [$];
    int                   burst_left = 0;

    duplicate_packet_filter_unit #(
        .DEPTH(MEM_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .done     (done),
        .result   (result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Check every result word in the cycle it is strobed
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    function automatic item_t mk(logic cmd, logic [ID_W-1:0] snd, logic [ID_W-1:0] pkt);
        item_t w;
        w.command   = cmd;
        w.sender_id = snd;
        w.packet_id = pkt;
        return w;
    endfunction

    // Pick a fresh pair, a near miss of a recent one, or a recent one exactly
    function automatic item_t make_item(int fresh_pct, int insert_pct);
        logic [KEY_W-1:0] key;
        int               r;
        r = $urandom_range(0, 99);
        if (recent_pairs.size() == 0 || r < fresh_pct)
        begin
            key[KEY_W-1:ID_W] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom;
            key[ID_W-1:0]     = $urandom;
        end
        else
        begin
            key = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
            if (r < fresh_pct + 10)
                key[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
        end
        recent_pairs.push_back(key);
        if (recent_pairs.size() > POOL_SIZE)
            void'(recent_pairs.pop_front());
        return mk(($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_LOOKUP,
                  key[KEY_W-1:ID_W], key[ID_W-1:0]);
    endfunction

    // Present one word and hold it until the block takes it
    task automatic drive_word(item_t w);
        start <= 1'b1;
        item  <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_item(w);
    endtask

    // Drop start and idle the sender
    task automatic hold_off(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drain outstanding results, then write the capacity register
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.note_config(cap);
        cfg_valid <= 1'b0;
    endtask

    // Run random words under one capacity, in bursts with random gaps
    task automatic run_phase(logic [CAP_W-1:0] cap, int count, int fresh_pct, int insert_pct);
        write_capacity(cap);
        for (int i = 0; i < count; i++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 10);
                if ($urandom_range(0, 3) != 0)
                    hold_off($urandom_range(1, 300));
            end
            burst_left--;
            drive_word(make_item(fresh_pct, insert_pct));
        end
    endtask

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset capacity: ID extremes, miss, insert, duplicate, hit, swapped halves
        drive_word(mk(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000));
        drive_word(mk(CMD_INSERT, 32'h0000_0000, 32'h0000_0000));
        drive_word(mk(CMD_INSERT, 32'h0000_0000, 32'h0000_0000));
        drive_word(mk(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000));
        drive_word(mk(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        drive_word(mk(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000));
        drive_word(mk(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF));
        drive_word(mk(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        drive_word(mk(CMD_LOOKUP, 32'h1234_5678, 32'h9ABC_DEF0));
        drive_word(mk(CMD_INSERT, 32'h9ABC_DEF0, 32'h1234_5678));
        drive_word(mk(CMD_LOOKUP, 32'h1234_5678, 32'h9ABC_DEF0));

        // Disabled cache: nothing found, nothing added
        write_capacity(9'd0);
        drive_word(mk(CMD_INSERT, 32'h0000_0001, 32'h0000_0001));
        drive_word(mk(CMD_LOOKUP, 32'h0000_0001, 32'h0000_0001));

        // Single slot: duplicate, then eviction by a new pair
        write_capacity(9'd1);
        drive_word(mk(CMD_INSERT, 32'h0000_0005, 32'h0000_0005));
        drive_word(mk(CMD_INSERT, 32'h0000_0005, 32'h0000_0005));
        drive_word(mk(CMD_INSERT, 32'h0000_0005, 32'h0000_0006));
        drive_word(mk(CMD_LOOKUP, 32'h0000_0005, 32'h0000_0005));
        drive_word(mk(CMD_LOOKUP, 32'h0000_0005, 32'h0000_0006));

        // Random phases; the saturated one fills and wraps the whole ring
        run_phase(9'd4,   60,  35, 60);
        run_phase(9'd511, 380, 85, 85);
        run_phase(9'd0,   30,  35, 60);
        run_phase(9'd1,   40,  35, 60);
        run_phase(9'd2,   40,  35, 60);
        run_phase(9'($urandom_range(5, 40)), 50, 35, 60);
        run_phase(9'd256, 100, 35, 60);
        run_phase(9'd300, 50,  35, 60);
        run_phase(9'd17,  50,  35, 60);

        // Drain and watch for stray strobes
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_duplicate_packet_filter_unit: clean");
        else
            $display("tb_duplicate_packet_filter_unit: errors");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb_duplicate_packet_filter_unit: errors");
        $finish;
    end

endmodule
